// File: sv/qivr_pkg.sv
// Shared widths, types and constants for the quaternion inverse vector rotation.
package qivr_pkg;

  // Input field widths and the fixed-point fraction of the quaternion.
  localparam int QUAT_WIDTH = 16;
  localparam int VEL_WIDTH  = 32;
  localparam int QUAT_FRAC  = QUAT_WIDTH - 2;

  // Product of two quaternion components, and one rotation matrix entry.
  localparam int PROD_WIDTH  = 2 * QUAT_WIDTH;
  localparam int ENTRY_WIDTH = PROD_WIDTH + 1;

  // Entry times velocity, and the exact sum of one output component.
  localparam int TERM_WIDTH = ENTRY_WIDTH + VEL_WIDTH;
  localparam int ACC_WIDTH  = TERM_WIDTH + 3;

  // The sum carries the fraction bits of two quaternion factors.
  localparam int FRAC_SHIFT = 2 * QUAT_FRAC;

  typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
  typedef logic signed [VEL_WIDTH-1:0]   vel_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
  typedef logic signed [TERM_WIDTH-1:0]  term_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;

  // Half an output LSB, added before the final shift to round to nearest.
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_SHIFT - 1);

  // Saturation limits of an output component.
  localparam vel_t VEL_MAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
  localparam vel_t VEL_MIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};

endpackage

// File: sv/quaternion_inverse_vector_rotate_top.sv
// Top level of the quaternion inverse vector rotation pipeline.
// Throughput: one request per cycle; each stage moves on when the next is free.
// The five stages are products, matrix entries, entry by velocity, row sums, saturation.
// Reset: synchronous, active high; clears every valid bit, payload is not reset.
module quaternion_inverse_vector_rotate_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qivr_pkg::quat_t quat_w,
  input  qivr_pkg::quat_t quat_x,
  input  qivr_pkg::quat_t quat_y,
  input  qivr_pkg::quat_t quat_z,
  input  qivr_pkg::vel_t  vel_global_x,
  input  qivr_pkg::vel_t  vel_global_y,
  input  qivr_pkg::vel_t  vel_global_z,
  output logic            out_valid,
  input  logic            out_ready,
  output qivr_pkg::vel_t  vel_local_x,
  output qivr_pkg::vel_t  vel_local_y,
  output qivr_pkg::vel_t  vel_local_z,
  output logic            saturated
);
  import qivr_pkg::*;

  vel_t   vel_in [3];
  vel_t   vel_b [3];
  entry_t diag [3];
  entry_t off [3][2];
  acc_t   acc [3];
  vel_t   vel_res [3];
  logic   valid_b, ready_b;
  logic   valid_d, ready_d;

  assign vel_in[0] = vel_global_x;
  assign vel_in[1] = vel_global_y;
  assign vel_in[2] = vel_global_z;

  // Quaternion products and rotation matrix entries.
  qivr_quat_products u_products (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .vel_in    (vel_in),
    .out_valid (valid_b),
    .out_ready (ready_b),
    .diag      (diag),
    .off       (off),
    .vel_out   (vel_b)
  );

  // Matrix applied to the velocity vector.
  qivr_matrix_apply u_apply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_b),
    .in_ready  (ready_b),
    .diag      (diag),
    .off       (off),
    .vel       (vel_b),
    .out_valid (valid_d),
    .out_ready (ready_d),
    .acc       (acc)
  );

  // Rounding, saturation and the output register.
  qivr_round_sat u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_d),
    .in_ready  (ready_d),
    .acc       (acc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vel       (vel_res),
    .saturated (saturated)
  );

  assign vel_local_x = vel_res[0];
  assign vel_local_y = vel_res[1];
  assign vel_local_z = vel_res[2];

`ifndef NO_ASSERTIONS
  // A saturated result carries at least one clipped component.
  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (vel_local_x == VEL_MAX) || (vel_local_x == VEL_MIN) ||
      (vel_local_y == VEL_MAX) || (vel_local_y == VEL_MIN) ||
      (vel_local_z == VEL_MAX) || (vel_local_z == VEL_MIN))
    else $error("saturated flag without a clipped component");

  // The input stalls only when the pipeline is full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output was free");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");
`endif

endmodule

// File: sv/qivr_quat_products.sv
// Two pipeline stages: quaternion component products, then rotation matrix entries.
module qivr_quat_products (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qivr_pkg::quat_t quat_w,
  input  qivr_pkg::quat_t quat_x,
  input  qivr_pkg::quat_t quat_y,
  input  qivr_pkg::quat_t quat_z,
  input  qivr_pkg::vel_t  vel_in [3],
  output logic            out_valid,
  input  logic            out_ready,
  output qivr_pkg::entry_t diag [3],
  output qivr_pkg::entry_t off [3][2],
  output qivr_pkg::vel_t  vel_out [3]
);
  import qivr_pkg::*;

  logic  valid_a;
  logic  en_a;
  logic  en_b;
  prod_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  vel_t  vel_a [3];

  // A stage takes a new request when it is empty or its contents move on.
  assign en_b     = !out_valid || out_ready;
  assign en_a     = !valid_a || en_b;
  assign in_ready = en_a;

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) valid_a <= in_valid;
      if (en_b) out_valid <= valid_a;
    end
  end

  // First stage: the ten distinct products of quaternion components.
  always_ff @(posedge clk) begin
    if (en_a) begin
      ww <= prod_t'(quat_w) * prod_t'(quat_w);
      xx <= prod_t'(quat_x) * prod_t'(quat_x);
      yy <= prod_t'(quat_y) * prod_t'(quat_y);
      zz <= prod_t'(quat_z) * prod_t'(quat_z);
      xy <= prod_t'(quat_x) * prod_t'(quat_y);
      xz <= prod_t'(quat_x) * prod_t'(quat_z);
      yz <= prod_t'(quat_y) * prod_t'(quat_z);
      wx <= prod_t'(quat_w) * prod_t'(quat_x);
      wy <= prod_t'(quat_w) * prod_t'(quat_y);
      wz <= prod_t'(quat_w) * prod_t'(quat_z);
      vel_a <= vel_in;
    end
  end

  // Second stage: diagonal entries in full, off-diagonal entries at half weight.
  always_ff @(posedge clk) begin
    if (en_b) begin
      diag[0] <= entry_t'(ww) + entry_t'(xx) - entry_t'(yy) - entry_t'(zz);
      diag[1] <= entry_t'(ww) - entry_t'(xx) + entry_t'(yy) - entry_t'(zz);
      diag[2] <= entry_t'(ww) - entry_t'(xx) - entry_t'(yy) + entry_t'(zz);
      off[0][0] <= entry_t'(xy) + entry_t'(wz);
      off[0][1] <= entry_t'(xz) - entry_t'(wy);
      off[1][0] <= entry_t'(xy) - entry_t'(wz);
      off[1][1] <= entry_t'(yz) + entry_t'(wx);
      off[2][0] <= entry_t'(xz) + entry_t'(wy);
      off[2][1] <= entry_t'(yz) - entry_t'(wx);
      vel_out <= vel_a;
    end
  end

endmodule

// File: sv/qivr_matrix_apply.sv
// Two pipeline stages: matrix entry by velocity products, then the row sums.
module qivr_matrix_apply (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qivr_pkg::entry_t diag [3],
  input  qivr_pkg::entry_t off [3][2],
  input  qivr_pkg::vel_t   vel [3],
  output logic             out_valid,
  input  logic             out_ready,
  output qivr_pkg::acc_t   acc [3]
);
  import qivr_pkg::*;

  logic  valid_c;
  logic  en_c;
  logic  en_d;
  term_t t_diag [3];
  term_t t_off [3][2];

  assign en_d     = !out_valid || out_ready;
  assign en_c     = !valid_c || en_d;
  assign in_ready = en_c;

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_c) valid_c <= in_valid;
      if (en_d) out_valid <= valid_c;
    end
  end

  // Third stage: nine exact products. Row r takes its off-diagonal
  // velocities from the two columns other than r.
  always_ff @(posedge clk) begin
    if (en_c) begin
      t_diag[0]   <= term_t'(diag[0]) * term_t'(vel[0]);
      t_diag[1]   <= term_t'(diag[1]) * term_t'(vel[1]);
      t_diag[2]   <= term_t'(diag[2]) * term_t'(vel[2]);
      t_off[0][0] <= term_t'(off[0][0]) * term_t'(vel[1]);
      t_off[0][1] <= term_t'(off[0][1]) * term_t'(vel[2]);
      t_off[1][0] <= term_t'(off[1][0]) * term_t'(vel[0]);
      t_off[1][1] <= term_t'(off[1][1]) * term_t'(vel[2]);
      t_off[2][0] <= term_t'(off[2][0]) * term_t'(vel[0]);
      t_off[2][1] <= term_t'(off[2][1]) * term_t'(vel[1]);
    end
  end

  // Fourth stage: off-diagonal terms count twice; the rounding half is
  // folded into the same sum.
  always_ff @(posedge clk) begin
    if (en_d) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= acc_t'(t_diag[r]) + (acc_t'(t_off[r][0]) <<< 1)
                + (acc_t'(t_off[r][1]) <<< 1) + ROUND_HALF;
      end
    end
  end

endmodule

// File: sv/qivr_round_sat.sv
// Output stage: drops the fraction bits, saturates and holds the result.
module qivr_round_sat (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qivr_pkg::acc_t acc [3],
  output logic           out_valid,
  input  logic           out_ready,
  output qivr_pkg::vel_t vel [3],
  output logic           saturated
);
  import qivr_pkg::*;

  localparam int HI_WIDTH = ACC_WIDTH - (FRAC_SHIFT + VEL_WIDTH - 1);

  logic                en_e;
  logic [HI_WIDTH-1:0] hi [3];
  logic [2:0]          fits;
  vel_t                vel_next [3];

  assign en_e     = !out_valid || out_ready;
  assign in_ready = en_e;

  // A component fits when all bits above its result sign match that sign.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      hi[r]   = acc[r][ACC_WIDTH-1:FRAC_SHIFT+VEL_WIDTH-1];
      fits[r] = (&hi[r]) || !(|hi[r]);
      if (fits[r]) begin
        vel_next[r] = acc[r][FRAC_SHIFT+VEL_WIDTH-1:FRAC_SHIFT];
      end else if (acc[r][ACC_WIDTH-1]) begin
        vel_next[r] = VEL_MIN;
      end else begin
        vel_next[r] = VEL_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_e) begin
      out_valid <= in_valid;
    end
  end

  // Output register: holds a result while the consumer stalls.
  always_ff @(posedge clk) begin
    if (en_e) begin
      vel       <= vel_next;
      saturated <= !(&fits);
    end
  end

endmodule

// File: dv/qivr_checker.sv
// Checker for the quaternion inverse vector rotation: predicts each result and compares it.
`timescale 1ns / 1ps

module qivr_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  qivr_pkg::quat_t quat_w,
  input  qivr_pkg::quat_t quat_x,
  input  qivr_pkg::quat_t quat_y,
  input  qivr_pkg::quat_t quat_z,
  input  qivr_pkg::vel_t  vel_global_x,
  input  qivr_pkg::vel_t  vel_global_y,
  input  qivr_pkg::vel_t  vel_global_z,
  input  logic            out_valid,
  input  logic            out_ready,
  input  qivr_pkg::vel_t  vel_local_x,
  input  qivr_pkg::vel_t  vel_local_y,
  input  qivr_pkg::vel_t  vel_local_z,
  input  logic            saturated,
  output int              mismatch_count,
  output int              results_pending,
  output int              results_checked,
  output int              clipped_results
);
  import qivr_pkg::*;

  // Wide enough to hold every exact row sum with room to spare.
  typedef logic signed [127:0] wide_t;

  typedef struct {
    vel_t vx;
    vel_t vy;
    vel_t vz;
    logic clipped;
  } body_vel_t;

  body_vel_t body_vel_q[$];

  // Rounds an exact row sum to the velocity format and clips it to range.
  function automatic void round_and_clip(input wide_t row_sum, output vel_t v,
                                         output logic clipped);
    wide_t half;
    wide_t rounded;
    wide_t vmax;
    wide_t vmin;
    half = 1;
    half = half <<< (FRAC_SHIFT - 1);
    rounded = row_sum + half;
    rounded = rounded >>> FRAC_SHIFT;
    vmax = VEL_MAX;
    vmin = VEL_MIN;
    clipped = 1'b0;
    if (rounded > vmax) begin
      v = VEL_MAX;
      clipped = 1'b1;
    end else if (rounded < vmin) begin
      v = VEL_MIN;
      clipped = 1'b1;
    end else begin
      v = vel_t'(rounded);
    end
  endfunction

  // Body-frame velocity: vector part of conj(q) * (v, 0) * q, worked out exactly.
  function automatic body_vel_t rotate_to_body(input quat_t w_in, input quat_t x_in,
                                               input quat_t y_in, input quat_t z_in,
                                               input vel_t vx_in, input vel_t vy_in,
                                               input vel_t vz_in);
    wide_t w, x, y, z, vx, vy, vz;
    wide_t sx, sy, sz;
    logic cx, cy, cz;
    body_vel_t r;
    w = w_in;
    x = x_in;
    y = y_in;
    z = z_in;
    vx = vx_in;
    vy = vy_in;
    vz = vz_in;
    sx = (w*w + x*x - y*y - z*z) * vx + 2 * (x*y + w*z) * vy + 2 * (x*z - w*y) * vz;
    sy = 2 * (x*y - w*z) * vx + (w*w - x*x + y*y - z*z) * vy + 2 * (y*z + w*x) * vz;
    sz = 2 * (x*z + w*y) * vx + 2 * (y*z - w*x) * vy + (w*w - x*x - y*y + z*z) * vz;
    round_and_clip(sx, r.vx, cx);
    round_and_clip(sy, r.vy, cy);
    round_and_clip(sz, r.vz, cz);
    r.clipped = cx | cy | cz;
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string field, input longint predicted, input longint seen);
    if (predicted != seen) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, predicted, seen);
      mismatch_count++;
    end
  endtask

  // Predict on each accepted request, then compare each accepted result in order.
  always @(posedge clk) begin
    body_vel_t want;
    if (rst) begin
      body_vel_q.delete();
      mismatch_count  = 0;
      results_pending = 0;
      results_checked = 0;
      clipped_results = 0;
    end else begin
      if (in_valid && in_ready) begin
        body_vel_q.push_back(rotate_to_body(quat_w, quat_x, quat_y, quat_z,
                                            vel_global_x, vel_global_y, vel_global_z));
      end
      if (out_valid && out_ready) begin
        if (body_vel_q.size() == 0) begin
          $display("%0t: result with no request outstanding: x %0d y %0d z %0d sat %0b",
                   $time, vel_local_x, vel_local_y, vel_local_z, saturated);
          mismatch_count++;
        end else begin
          want = body_vel_q.pop_front();
          check_field("vel_local_x", want.vx, vel_local_x);
          check_field("vel_local_y", want.vy, vel_local_y);
          check_field("vel_local_z", want.vz, vel_local_z);
          check_field("saturated", want.clipped, saturated);
          results_checked++;
          if (want.clipped) begin
            clipped_results++;
          end
        end
      end
      results_pending = body_vel_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for the quaternion inverse vector rotation: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
  import qivr_pkg::*;

  localparam int RANDOM_POSES = 1630;
  localparam int DRAIN_CYCLES = 20;

  // Quaternion component values used by the directed requests.
  localparam quat_t Q_ZERO    = quat_t'(0);
  localparam quat_t Q_LSB     = quat_t'(1);
  localparam quat_t Q_ONE     = quat_t'(16384);
  localparam quat_t Q_RT_HALF = quat_t'(11585);
  localparam quat_t Q_MAX     = quat_t'(32767);
  localparam quat_t Q_MIN     = quat_t'(-32768);

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  quat_t quat_w;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  vel_t  vel_global_x;
  vel_t  vel_global_y;
  vel_t  vel_global_z;
  logic  out_valid;
  logic  out_ready;
  vel_t  vel_local_x;
  vel_t  vel_local_y;
  vel_t  vel_local_z;
  logic  saturated;

  int mismatch_count;
  int results_pending;
  int results_checked;
  int clipped_results;
  int poses_sent;
  logic no_gaps;

  quaternion_inverse_vector_rotate_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .quat_w       (quat_w),
    .quat_x       (quat_x),
    .quat_y       (quat_y),
    .quat_z       (quat_z),
    .vel_global_x (vel_global_x),
    .vel_global_y (vel_global_y),
    .vel_global_z (vel_global_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vel_local_x  (vel_local_x),
    .vel_local_y  (vel_local_y),
    .vel_local_z  (vel_local_z),
    .saturated    (saturated)
  );

  qivr_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .quat_w          (quat_w),
    .quat_x          (quat_x),
    .quat_y          (quat_y),
    .quat_z          (quat_z),
    .vel_global_x    (vel_global_x),
    .vel_global_y    (vel_global_y),
    .vel_global_z    (vel_global_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .vel_local_x     (vel_local_x),
    .vel_local_y     (vel_local_y),
    .vel_local_z     (vel_local_z),
    .saturated       (saturated),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .results_checked (results_checked),
    .clipped_results (clipped_results)
  );

  // Free-running clock with a 4 ns period.
  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Receiver back-pressure: runs of ready and of stall, some long stretches of ready.
  initial begin
    int r;
    int run;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready = 1'b1;
        run = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      end else begin
        out_ready = 1'b0;
        run = pick_gap();
      end
      if (run > 1) begin
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  // Presents one request and holds it until accepted; called and left at a falling edge.
  task automatic send_pose(input quat_t w, input quat_t x, input quat_t y, input quat_t z,
                           input vel_t vx, input vel_t vy, input vel_t vz);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    quat_w = w;
    quat_x = x;
    quat_y = y;
    quat_z = z;
    vel_global_x = vx;
    vel_global_y = vy;
    vel_global_z = vz;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    poses_sent++;
    @(negedge clk);
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (results_pending != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // One quaternion component drawn from the interesting values of the format.
  function automatic quat_t corner_quat();
    case ($urandom_range(0, 6))
      0: return quat_t'(-32768);
      1: return quat_t'(32767);
      2: return quat_t'(0);
      3: return quat_t'(1);
      4: return quat_t'(-1);
      5: return quat_t'(16384);
      default: return quat_t'(-16384);
    endcase
  endfunction

  // One velocity component: full range, scaled down, or a corner value.
  function automatic vel_t pick_vel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return vel_t'($urandom);
    end else if (r < 90) begin
      return vel_t'($signed($urandom) >>> $urandom_range(1, 28));
    end
    case ($urandom_range(0, 4))
      0: return VEL_MIN;
      1: return VEL_MAX;
      2: return vel_t'(0);
      3: return vel_t'(-1);
      default: return vel_t'(1);
    endcase
  endfunction

  // Random request: half unit quaternions, the rest raw bits, corners or small values.
  task automatic send_random_pose();
    real a, b, c, d, n;
    quat_t w, x, y, z;
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      a = $urandom_range(0, 65535) - 32768.0;
      b = $urandom_range(0, 65535) - 32768.0;
      c = $urandom_range(0, 65535) - 32768.0;
      d = $urandom_range(0, 65535) - 32768.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        a = 1.0;
        n = 1.0;
      end
      w = quat_t'($rtoi(a / n * 16384.0));
      x = quat_t'($rtoi(b / n * 16384.0));
      y = quat_t'($rtoi(c / n * 16384.0));
      z = quat_t'($rtoi(d / n * 16384.0));
    end else if (r < 70) begin
      w = quat_t'($urandom);
      x = quat_t'($urandom);
      y = quat_t'($urandom);
      z = quat_t'($urandom);
    end else if (r < 85) begin
      w = corner_quat();
      x = corner_quat();
      y = corner_quat();
      z = corner_quat();
    end else begin
      w = quat_t'($signed($urandom) >>> 20);
      x = quat_t'($signed($urandom) >>> 20);
      y = quat_t'($signed($urandom) >>> 20);
      z = quat_t'($signed($urandom) >>> 20);
    end
    send_pose(w, x, y, z, pick_vel(), pick_vel(), pick_vel());
  endtask

  // Reset, directed requests, random requests, drain and verdict.
  initial begin
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    quat_w = '0;
    quat_x = '0;
    quat_y = '0;
    quat_z = '0;
    vel_global_x = '0;
    vel_global_y = '0;
    vel_global_z = '0;
    no_gaps = 1'b0;
    poses_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Identity and the quarter and half turns about each axis.
    send_pose(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 32'sh0001_0000, -32'sh0001_0000, 12345);
    send_pose(Q_RT_HALF, Q_ZERO, Q_ZERO, Q_RT_HALF,
              32'sh0003_0000, 32'sh0001_8000, -32'sh0000_4000);
    send_pose(Q_RT_HALF, Q_RT_HALF, Q_ZERO, Q_ZERO, -7, 32'sh0010_0000, 32'sh0020_0000);
    send_pose(Q_RT_HALF, Q_ZERO, -Q_RT_HALF, Q_ZERO, 32'sh0123_4567, 99999, -1);
    send_pose(Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    send_pose(Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, -32'sh0001_0000, 32'sh0002_0000, 32'sh7000_0000);
    send_pose(Q_ZERO, Q_ZERO, Q_ZERO, -Q_ONE, 1, -1, 2);
    // Identity carries the velocity extremes through unchanged.
    send_pose(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, VEL_MIN, VEL_MAX, 0);
    send_pose(-Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, VEL_MAX, VEL_MIN, -1);
    // Rounding ties go towards plus infinity.
    send_pose(Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO, 32'sh0800_0000, -32'sh0800_0000, 32'sh1800_0000);
    send_pose(Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO, -32'sh1800_0000, 32'sh0000_0001, -32'sh0000_0001);
    // A zero quaternion and a zero velocity.
    send_pose(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, VEL_MAX, VEL_MIN, VEL_MAX);
    send_pose(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0);
    // Field extremes on a non-unit quaternion drive every component into saturation.
    send_pose(Q_MIN, Q_MIN, Q_MIN, Q_MIN, VEL_MAX, VEL_MAX, VEL_MAX);
    send_pose(Q_MAX, Q_MAX, Q_MAX, Q_MAX, VEL_MIN, VEL_MIN, VEL_MIN);
    send_pose(Q_MIN, Q_MAX, Q_MIN, Q_MAX, VEL_MIN, VEL_MAX, VEL_MIN);
    // Only one component clips; the other two stay in range.
    send_pose(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, 32'sh4000_0000, 5, -5);
    // A non-unit quaternion small enough not to clip.
    send_pose(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1000, -2000, 3000);
    send_pose(Q_LSB, -Q_LSB, Q_LSB, -Q_LSB, VEL_MAX, VEL_MIN, 1);

    wait_for_drain();

    // Random requests, with stretches where the sender never pauses.
    for (k = 0; k < RANDOM_POSES; k++) begin
      no_gaps = ((k % 300) >= 220);
      send_random_pose();
      if (k == RANDOM_POSES / 2) begin
        wait_for_drain();
      end
    end
    in_valid = 1'b0;

    while (results_pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d poses and checked %0d rotated velocities, %0d of them clipped.",
             poses_sent, results_checked, clipped_results);
    if (mismatch_count == 0) begin
      $display("quaternion_inverse_vector_rotate_top regression: pass");
    end else begin
      $display("Mismatches found: %0d.", mismatch_count);
      $display("quaternion_inverse_vector_rotate_top regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", results_pending);
    $display("quaternion_inverse_vector_rotate_top regression: fail");
    $finish;
  end

endmodule
